### sv/mbq_pkg.sv
`timescale 1ns / 1ps

package mbq_pkg;

  localparam logic [1:0] REQ_APPEND = 2'd0;
  localparam logic [1:0] REQ_PEEK   = 2'd1;
  localparam logic [1:0] REQ_DROP   = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_LONG = 2'd1;
  localparam logic [1:0] ST_SHORT    = 2'd2;
  localparam logic [1:0] ST_OVERFLOW = 2'd3;

  localparam int MAX_FIELD = 16;
  localparam int BYTE_BITS = 8;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [8:0]  bit_count;
    logic [15:0] value;
  } req_t;

  typedef struct packed {
    logic [15:0] front_value;
    logic [9:0]  bits_held;
    logic [1:0]  status;
  } rsp_t;

endpackage

### sv/msb_first_bit_queue.sv
// MSB-first bit queue stored as packed bytes in a single-port byte RAM.
// Request channel (req_valid/req_ready, req): append the low 0..16 bits of
// value at the tail, peek the first 0..16 bits at the head, or drop any
// number of bits from the head. Response channel (rsp_valid/rsp_ready, rsp):
// one response per request with the peeked bits, the bit count afterwards
// and a status. Failing requests change nothing.
// Work per request, from accept to response:
//   drop, rejected or unknown request: no RAM access
//   peek:   three byte reads through the single RAM port
//   append: three byte reads, merge, three byte writes
// One request is in work at a time; the RAM port sets the rate.
// A finished response sits in an output register; a new request is taken
// while it waits. If the receiver stalls and a second result is ready, the
// engine holds it until the output register frees.
// Reset empties the queue (head and count to zero) and drops any pending
// response; the RAM contents are not cleared and need no clearing pass.
`timescale 1ns / 1ps

module msb_first_bit_queue
  import mbq_pkg::*;
#(
  parameter int CAPACITY_BYTES = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int RING_BITS = CAPACITY_BYTES * BYTE_BITS;
  localparam int AW = $clog2(CAPACITY_BYTES);
  localparam int PW = $clog2(RING_BITS);
  localparam int CW = $clog2(RING_BITS + 1);
  localparam int EW = ((CW > 9) ? CW : 9) + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_LAST, S_WRITE, S_DONE} state_t;

  state_t        state;
  logic [1:0]    cnt;
  logic [PW-1:0] head;
  logic [CW-1:0] held;
  logic [AW-1:0] base;
  logic [AW-1:0] cur;
  logic [AW-1:0] cur_inc;
  logic [2:0]    off;
  logic [4:0]    nbits;
  logic [15:0]   val;
  logic          is_app;
  logic [23:0]   win;
  logic [15:0]   res_front;
  logic [9:0]    res_held;
  logic [1:0]    res_status;

  logic [EW-1:0] held_e, n_e, ring_e, sum_e, tail_e, drop_e;
  logic          too_long, overflow, short_q;
  logic [1:0]    st_new;
  logic [CW-1:0] held_new;
  logic [PW-1:0] head_new;
  logic [PW-1:0] start;
  logic          go_mem;

  logic          ram_we;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  logic [23:0]   w_full, ext, placed, mask, merged, pk;
  logic [4:0]    shl;
  logic [15:0]   front;

  assign req_ready = (state == S_IDLE);

  always_comb begin
    held_e   = EW'(held);
    n_e      = EW'(req.bit_count);
    ring_e   = EW'(RING_BITS);
    sum_e    = held_e + n_e;
    too_long = (req.bit_count > 9'(MAX_FIELD));
    overflow = (sum_e > ring_e);
    short_q  = (n_e > held_e);
    tail_e   = EW'(head) + held_e;
    if (tail_e >= ring_e) begin
      tail_e = tail_e - ring_e;
    end
    drop_e = EW'(head) + n_e;
    if (drop_e >= ring_e) begin
      drop_e = drop_e - ring_e;
    end
  end

  always_comb begin
    st_new   = ST_OK;
    held_new = held;
    head_new = head;
    start    = head;
    go_mem   = 1'b0;
    unique case (req.req_type)
      REQ_APPEND: begin
        if (too_long) begin
          st_new = ST_TOO_LONG;
        end else if (overflow) begin
          st_new = ST_OVERFLOW;
        end else begin
          go_mem   = 1'b1;
          held_new = CW'(sum_e);
          start    = PW'(tail_e);
        end
      end
      REQ_PEEK: begin
        if (too_long) begin
          st_new = ST_TOO_LONG;
        end else if (short_q) begin
          st_new = ST_SHORT;
        end else begin
          go_mem = 1'b1;
        end
      end
      REQ_DROP: begin
        if (short_q) begin
          st_new = ST_SHORT;
        end else begin
          head_new = PW'(drop_e);
          held_new = CW'(held_e - n_e);
        end
      end
      default: begin
      end
    endcase
  end

  assign cur_inc = (cur == AW'(CAPACITY_BYTES - 1)) ? '0 : cur + 1'b1;

  // 24-bit window over three bytes starting at the byte holding the start bit
  always_comb begin
    w_full = {win[23:8], ram_rdata};
    shl    = 5'(MAX_FIELD) - nbits;
    ext    = {val, 8'h00} << shl;
    placed = ext >> off;
    mask   = ({16'hffff, 8'h00} << shl) >> off;
    merged = (w_full & ~mask) | (placed & mask);
    pk     = w_full << off;
    front  = pk[23:8] >> shl;
  end

  always_comb begin
    ram_we = (state == S_WRITE);
    unique case (cnt)
      2'd0:    ram_wdata = win[23:16];
      2'd1:    ram_wdata = win[15:8];
      default: ram_wdata = win[7:0];
    endcase
  end

  mbq_ram #(
    .DEPTH(CAPACITY_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (cur),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      head      <= '0;
      held      <= '0;
    end else begin
      if (rsp_valid && rsp_ready && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            head       <= head_new;
            held       <= held_new;
            res_status <= st_new;
            res_held   <= 10'(held_new);
            res_front  <= '0;
            base       <= start[PW-1:3];
            cur        <= start[PW-1:3];
            off        <= start[2:0];
            nbits      <= 5'(req.bit_count);
            val        <= req.value;
            is_app     <= (req.req_type == REQ_APPEND);
            cnt        <= '0;
            state      <= go_mem ? S_READ : S_DONE;
          end
        end
        S_READ: begin
          cur <= cur_inc;
          cnt <= cnt + 1'b1;
          unique case (cnt)
            2'd1:    win[23:16] <= ram_rdata;
            2'd2:    win[15:8]  <= ram_rdata;
            default: begin
            end
          endcase
          if (cnt == 2'd2) begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (is_app) begin
            win   <= merged;
            cur   <= base;
            cnt   <= '0;
            state <= S_WRITE;
          end else begin
            res_front <= front;
            state     <= S_DONE;
          end
        end
        S_WRITE: begin
          cur <= cur_inc;
          cnt <= cnt + 1'b1;
          if (cnt == 2'd2) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= '{front_value: res_front, bits_held: res_held,
                           status: res_status};
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### sv/mbq_ram.sv
`timescale 1ns / 1ps

module mbq_ram #(
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/mbq_checker.sv
`timescale 1ns / 1ps

module mbq_checker
  import mbq_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_fail_no_data: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.front_value == 16'h0000))
    else $error("failed request returned front bits");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

endmodule

bind msb_first_bit_queue mbq_checker u_mbq_checker (.*);
